// ----- hdl/bbt_pkg.sv -----
// ----------------------------------------------------------------------------
// bbt_pkg: shared definitions for the per-level bounding box tracker
// Default sizes and the request operation codes.
// ----------------------------------------------------------------------------
package bbt_pkg;

  localparam int COORD_BITS_DEF  = 8;
  localparam int LEVEL_COUNT_DEF = 16;
  localparam int TALLY_BITS_DEF  = 16;

  // Operation codes carried on in_tuser
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

endpackage

// ----- hdl/bbt_ram.sv -----
// ----------------------------------------------------------------------------
// bbt_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bbt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/per_level_bounding_box_tracker.sv -----
// ----------------------------------------------------------------------------
// per_level_bounding_box_tracker: reference-counted bounding boxes per level
// Sequence: a taken add/remove request runs read, write, a scan of the tallies
//   (one tally entry per cycle through the scan/compare unit) and finish, after
//   which out_tvalid rises; a clear runs a clearing pass, then the scan and finish.
// Throughput: one request at a time; in_tready is low while one is at work or its
//   result waits, and while a vanished level's y row is cleared.
// Reset: a clearing pass over all 2^(LVL_W+COORD_BITS) level entries runs first.
// ----------------------------------------------------------------------------
module per_level_bounding_box_tracker #(
  parameter int COORD_BITS  = bbt_pkg::COORD_BITS_DEF,
  parameter int LEVEL_COUNT = bbt_pkg::LEVEL_COUNT_DEF,
  parameter int TALLY_BITS  = bbt_pkg::TALLY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // x_coord[7:0], y_coord[15:8], level[19:16], zero pad
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // changed[0], level_present[1], level_min_x[9:2], level_max_x[17:10],
  // level_min_y[25:18], level_max_y[33:26], any_present[34], total_min_x[42:35],
  // total_max_x[50:43], total_min_y[58:51], total_max_y[66:59], zero pad
  output logic [71:0] out_tdata
);

  localparam int SPAN  = 1 << COORD_BITS;
  localparam int HALF  = 1 << (COORD_BITS - 1);
  localparam int CXW   = (COORD_BITS > 8) ? COORD_BITS : 8;
  localparam int LVL_W = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
  localparam int LA_W  = LVL_W + COORD_BITS;
  localparam int LDEP  = 1 << LA_W;
  localparam int CNT_W = LA_W + 1;
  localparam int BW    = 4 * COORD_BITS + 1;

  typedef enum logic [6:0] {
    S_INIT = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_RD   = 7'b0000100,
    S_WR   = 7'b0001000,
    S_SCAN = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_YCLR = 7'b1000000
  } state_t;

  typedef logic [COORD_BITS-1:0] idx_t;
  typedef logic [TALLY_BITS-1:0] tally_t;

  // Saturate a raw coordinate into the tally index range
  function automatic idx_t coord_idx(input logic [7:0] raw);
    logic signed [CXW-1:0] v;
    logic signed [CXW-1:0] lo;
    logic signed [CXW-1:0] hi;
    v  = CXW'(signed'(raw));
    lo = CXW'(-HALF);
    hi = CXW'(HALF - 1);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return COORD_BITS'(v - lo);
  endfunction

  // Index back to a signed coordinate, low byte
  function automatic logic [7:0] to_byte(input idx_t idx);
    logic [CXW-1:0] v;
    v = CXW'(idx) - CXW'(HALF);
    return v[7:0];
  endfunction

  // Level bits taken unsigned, folded into the level range
  function automatic logic [LVL_W-1:0] lvl_fold(input logic [3:0] raw);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int k = 0; k < 16; k++) begin
      if (raw == 4'(k)) r = LVL_W'(k % LEVEL_COUNT);
    end
    return r;
  endfunction

  // Saturating count update
  function automatic tally_t tally_upd(input tally_t t, input logic add);
    tally_t r;
    r = t;
    if (add) begin
      if (t != '1) r = t + tally_t'(1);
    end else begin
      if (t != '0) r = t - tally_t'(1);
    end
    return r;
  endfunction

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        op_r;
  idx_t              xi_r, yi_r;
  logic [LVL_W-1:0]  lv_r;
  logic              was_r;
  logic              clr_item_r;
  logic [LEVEL_COUNT-1:0] lvalid_r;
  logic              found_r [4];
  idx_t              mn_r [4];
  idx_t              mx_r [4];
  logic [71:0]       out_r;
  logic              out_v_r;

  tally_t            rd [4];
  tally_t            wd [4];
  logic              we_lvl, we_all, we_ly;
  logic [LA_W-1:0]   ax_lvl, ay_lvl;
  idx_t              ax_all, ay_all;
  logic [BW-1:0]     bnd_rd, bnd_wd;
  logic              bnd_we;
  logic              upd;
  idx_t              scan_idx;

  assign upd       = (op_r == bbt_pkg::OP_ADD) || (op_r == bbt_pkg::OP_REMOVE && was_r);
  assign scan_idx  = cnt_r[COORD_BITS-1:0] - idx_t'(1);
  assign in_tready = (state_r == S_IDLE) && !out_v_r;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r;

  // Address and write steering for the tally memories
  always_comb begin
    ax_lvl = {lv_r, cnt_r[COORD_BITS-1:0]};
    ay_lvl = {lv_r, cnt_r[COORD_BITS-1:0]};
    ax_all = cnt_r[COORD_BITS-1:0];
    ay_all = cnt_r[COORD_BITS-1:0];
    we_lvl = 1'b0;
    we_all = 1'b0;
    we_ly  = 1'b0;
    wd[0]  = '0;
    wd[1]  = '0;
    wd[2]  = '0;
    wd[3]  = '0;
    unique case (state_r)
      S_INIT: begin
        ax_lvl = cnt_r[LA_W-1:0];
        ay_lvl = cnt_r[LA_W-1:0];
        we_lvl = 1'b1;
        we_all = 1'b1;
      end
      S_RD, S_WR: begin
        ax_lvl = {lv_r, xi_r};
        ay_lvl = {lv_r, yi_r};
        ax_all = xi_r;
        ay_all = yi_r;
        we_lvl = (state_r == S_WR) && upd;
        we_all = (state_r == S_WR) && upd;
        wd[0]  = tally_upd(rd[0], op_r == bbt_pkg::OP_ADD);
        wd[1]  = tally_upd(rd[1], op_r == bbt_pkg::OP_ADD);
        wd[2]  = tally_upd(rd[2], op_r == bbt_pkg::OP_ADD);
        wd[3]  = tally_upd(rd[3], op_r == bbt_pkg::OP_ADD);
      end
      S_YCLR: begin
        we_ly = 1'b1;
      end
      default: begin
      end
    endcase
  end

  bbt_ram #(.WIDTH(TALLY_BITS), .DEPTH(LDEP)) u_lvl_x (
    .clk(clk), .we(we_lvl), .waddr(ax_lvl), .wdata(wd[0]), .raddr(ax_lvl), .rdata(rd[0])
  );
  bbt_ram #(.WIDTH(TALLY_BITS), .DEPTH(LDEP)) u_lvl_y (
    .clk(clk), .we(we_lvl | we_ly), .waddr(ay_lvl), .wdata(wd[1]), .raddr(ay_lvl),
    .rdata(rd[1])
  );
  bbt_ram #(.WIDTH(TALLY_BITS), .DEPTH(SPAN)) u_all_x (
    .clk(clk), .we(we_all), .waddr(ax_all), .wdata(wd[2]), .raddr(ax_all), .rdata(rd[2])
  );
  bbt_ram #(.WIDTH(TALLY_BITS), .DEPTH(SPAN)) u_all_y (
    .clk(clk), .we(we_all), .waddr(ay_all), .wdata(wd[3]), .raddr(ay_all), .rdata(rd[3])
  );
  bbt_ram #(.WIDTH(BW), .DEPTH(1 << LVL_W)) u_bounds (
    .clk(clk), .we(bnd_we), .waddr(lv_r), .wdata(bnd_wd), .raddr(lv_r), .rdata(bnd_rd)
  );

  // Final box evaluation
  idx_t        e_mn [4];
  idx_t        e_mx [4];
  logic        chg, vanish, valid_after;
  logic [BW-1:0] box_now;
  logic [71:0] out_nxt;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      e_mn[k] = found_r[k] ? mn_r[k] : idx_t'(HALF);
      e_mx[k] = found_r[k] ? mx_r[k] : idx_t'(HALF);
    end
    box_now = {found_r[1], e_mx[1], e_mn[1], e_mx[0], e_mn[0]};
    chg     = 1'b0;
    vanish  = 1'b0;
    valid_after = was_r;
    unique case (op_r)
      bbt_pkg::OP_ADD: begin
        chg = !was_r || (box_now != bnd_rd);
        valid_after = 1'b1;
      end
      bbt_pkg::OP_REMOVE: begin
        if (was_r) begin
          vanish = !found_r[0];
          chg    = vanish || (box_now != bnd_rd);
          valid_after = !vanish;
        end
      end
      bbt_pkg::OP_CLEAR: begin
        chg = was_r;
        valid_after = 1'b0;
      end
      default: begin
      end
    endcase
    bnd_we = (state_r == S_FIN) && valid_after;
    bnd_wd = box_now;
    // pack the result word
    out_nxt    = '0;
    out_nxt[0] = chg;
    out_nxt[1] = valid_after;
    if (valid_after) begin
      out_nxt[9:2]   = to_byte(e_mn[0]);
      out_nxt[17:10] = to_byte(e_mx[0]);
      out_nxt[25:18] = to_byte(e_mn[1]);
      out_nxt[33:26] = to_byte(e_mx[1]);
    end
    out_nxt[34] = found_r[2];
    if (found_r[2]) begin
      out_nxt[42:35] = to_byte(e_mn[2]);
      out_nxt[50:43] = to_byte(e_mx[2]);
      out_nxt[58:51] = to_byte(e_mn[3]);
      out_nxt[66:59] = to_byte(e_mx[3]);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_INIT: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(LDEP - 1)) begin
          cnt_nxt   = '0;
          state_nxt = clr_item_r ? S_SCAN : S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid && !out_v_r) begin
          if (in_tuser == bbt_pkg::OP_CLEAR) state_nxt = S_INIT;
          else state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_WR;
      S_WR: state_nxt = S_SCAN;
      S_SCAN: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SPAN)) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cnt_nxt   = '0;
        state_nxt = vanish ? S_YCLR : S_IDLE;
      end
      S_YCLR: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SPAN - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_INIT;
      cnt_r      <= '0;
      clr_item_r <= 1'b0;
      lvalid_r   <= '0;
      out_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      // hold the result until taken
      if (out_v_r && out_tready) out_v_r <= 1'b0;
      if (state_r == S_IDLE && in_tvalid && !out_v_r) begin
        clr_item_r <= (in_tuser == bbt_pkg::OP_CLEAR);
        if (in_tuser == bbt_pkg::OP_CLEAR) lvalid_r <= '0;
      end
      if (state_r == S_FIN) begin
        lvalid_r[lv_r] <= valid_after;
        out_v_r        <= 1'b1;
      end
    end
  end

  // Request capture, scan tracking and result register
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid && !out_v_r) begin
      op_r  <= in_tuser;
      xi_r  <= coord_idx(in_tdata[7:0]);
      yi_r  <= coord_idx(in_tdata[15:8]);
      lv_r  <= lvl_fold(in_tdata[19:16]);
      was_r <= lvalid_r[lvl_fold(in_tdata[19:16])];
    end
    // compare unit: one entry of each tally per cycle
    for (int k = 0; k < 4; k++) begin
      if (state_r != S_SCAN) begin
        found_r[k] <= 1'b0;
      end else if (cnt_r != '0 && rd[k] != '0) begin
        if (!found_r[k]) mn_r[k] <= scan_idx;
        mx_r[k]    <= scan_idx;
        found_r[k] <= 1'b1;
      end
    end
    if (state_r == S_FIN) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ----- tb/sv/tb_per_level_bounding_box_tracker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_level_bounding_box_tracker: self-checking bench for the box tracker
// Drives add/remove/clear requests on the input stream and checks every result
// against a behavioral copy of the per-level and all-levels count stores.
// ----------------------------------------------------------------------------
module tb_per_level_bounding_box_tracker;

  localparam int NLEV = 16;
  localparam int SPAN = 256;
  localparam int TALLY_MAX = 65535;
  localparam int RANDOM_ITEMS = 850;
  localparam int CYCLE_LIMIT = 5000000;

  typedef struct packed {
    logic [7:0] tmaxy, tminy, tmaxx, tminx;
    logic       any;
    logic [7:0] lmaxy, lminy, lmaxx, lminx;
    logic       present;
    logic       changed;
  } box_report_t;

  typedef struct {
    logic [1:0] op;
    logic [7:0] x, y;
    logic [3:0] lv;
    logic       has_exp;
    logic [66:0] exp_bits;
  } request_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [71:0] out_tdata;

  per_level_bounding_box_tracker dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Behavioral count stores
  int unsigned lvl_x_cnt[NLEV][SPAN];
  int unsigned lvl_y_cnt[NLEV][SPAN];
  int unsigned tot_x_cnt[SPAN];
  int unsigned tot_y_cnt[SPAN];
  bit          lvl_live[NLEV];

  box_report_t pending_reports[$];
  logic        pending_fixed[$];
  box_report_t fixed_reports[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          quiet_phase = 0;
  bit          hold_off = 0;
  bit          stim_done = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Find min/max of a count row; absent axis reports zero
  function automatic bit row_span(input int unsigned row[SPAN],
                                  output logic [7:0] lo, output logic [7:0] hi);
    bit found;
    found = 0;
    lo = '0;
    hi = '0;
    for (int i = 0; i < SPAN; i++) begin
      if (row[i] != 0) begin
        if (!found) lo = 8'(i - 128);
        hi = 8'(i - 128);
        found = 1;
      end
    end
    return found;
  endfunction

  function automatic logic [33:0] level_box(input int l);
    logic [7:0] a, b, c, d;
    bit xp, yp;
    xp = row_span(lvl_x_cnt[l], a, b);
    yp = row_span(lvl_y_cnt[l], c, d);
    return {xp, yp, a, b, c, d};
  endfunction

  // Apply one request to the stores and return the expected report
  function automatic box_report_t apply_request(input logic [1:0] op, input logic [7:0] x,
                                                input logic [7:0] y, input logic [3:0] lvr);
    box_report_t r;
    int xi, yi, l;
    logic [33:0] prior, after;
    bit xp, yp;
    xi = int'($signed(x)) + 128;
    yi = int'($signed(y)) + 128;
    l = lvr;
    r = '0;
    if (op == bbt_pkg::OP_ADD) begin
      if (tot_x_cnt[xi] < TALLY_MAX) tot_x_cnt[xi]++;
      if (tot_y_cnt[yi] < TALLY_MAX) tot_y_cnt[yi]++;
      prior = level_box(l);
      if (lvl_x_cnt[l][xi] < TALLY_MAX) lvl_x_cnt[l][xi]++;
      if (lvl_y_cnt[l][yi] < TALLY_MAX) lvl_y_cnt[l][yi]++;
      after = level_box(l);
      r.changed = !lvl_live[l] || (prior != after);
      lvl_live[l] = 1;
    end else if (op == bbt_pkg::OP_REMOVE) begin
      if (lvl_live[l]) begin
        if (tot_x_cnt[xi] > 0) tot_x_cnt[xi]--;
        if (tot_y_cnt[yi] > 0) tot_y_cnt[yi]--;
        prior = level_box(l);
        if (lvl_x_cnt[l][xi] > 0) lvl_x_cnt[l][xi]--;
        if (lvl_y_cnt[l][yi] > 0) lvl_y_cnt[l][yi]--;
        after = level_box(l);
        if (!after[33]) begin
          // level vanishes: drop its y row as well
          for (int i = 0; i < SPAN; i++) lvl_y_cnt[l][i] = 0;
          lvl_live[l] = 0;
          r.changed = 1;
        end else begin
          r.changed = prior != after;
        end
      end
    end else if (op == bbt_pkg::OP_CLEAR) begin
      r.changed = lvl_live[l];
      for (int k = 0; k < NLEV; k++) begin
        lvl_live[k] = 0;
        for (int i = 0; i < SPAN; i++) begin
          lvl_x_cnt[k][i] = 0;
          lvl_y_cnt[k][i] = 0;
        end
      end
      for (int i = 0; i < SPAN; i++) begin
        tot_x_cnt[i] = 0;
        tot_y_cnt[i] = 0;
      end
    end
    if (lvl_live[l]) begin
      xp = row_span(lvl_x_cnt[l], r.lminx, r.lmaxx);
      yp = row_span(lvl_y_cnt[l], r.lminy, r.lmaxy);
      r.present = 1;
    end
    xp = row_span(tot_x_cnt, r.tminx, r.tmaxx);
    if (xp) begin
      yp = row_span(tot_y_cnt, r.tminy, r.tmaxy);
      r.any = 1;
    end else begin
      r.tminy = '0;
      r.tmaxy = '0;
    end
    return r;
  endfunction

  // Directed rows; expected bits typed in where obvious, else predicted
  request_t directed[$];

  task automatic add_row(input logic [1:0] op, input logic [7:0] x, input logic [7:0] y,
                         input logic [3:0] lv, input logic has_exp, input logic [66:0] e);
    request_t q;
    q.op = op; q.x = x; q.y = y; q.lv = lv; q.has_exp = has_exp; q.exp_bits = e;
    directed.push_back(q);
  endtask

  // Send one request, honoring random idle cycles
  task automatic send_request(input logic [1:0] op, input logic [7:0] x,
                              input logic [7:0] y, input logic [3:0] lv,
                              input logic has_exp, input logic [66:0] e);
    box_report_t p;
    while (!quiet_phase && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'b0, lv, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = apply_request(op, x, y, lv);
    pending_reports.push_back(p);
    pending_fixed.push_back(has_exp);
    fixed_reports.push_back(box_report_t'(e));
  endtask

  // Result side: random stalls plus a long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      out_tready <= !hold_off && (quiet_phase || $urandom_range(99) >= 19);
    end
  end

  always @(posedge clk) begin
    box_report_t got, want, typed;
    logic fx;
    cycle_count <= cycle_count + 1;
    if (out_tvalid && out_tready) begin
      got = box_report_t'(out_tdata[66:0]);
      if (pending_reports.size() == 0) begin
        report_mismatch("unexpected result", int'(out_tdata[34:0]), 0);
      end else begin
        want = pending_reports.pop_front();
        fx = pending_fixed.pop_front();
        typed = fixed_reports.pop_front();
        if (fx && typed != want) report_mismatch("typed row vs predictor", 0, 1);
        if (got.changed !== want.changed) report_mismatch("changed", got.changed, want.changed);
        if (got.present !== want.present) report_mismatch("level_present", got.present, want.present);
        if (got.lminx !== want.lminx) report_mismatch("level_min_x", got.lminx, want.lminx);
        if (got.lmaxx !== want.lmaxx) report_mismatch("level_max_x", got.lmaxx, want.lmaxx);
        if (got.lminy !== want.lminy) report_mismatch("level_min_y", got.lminy, want.lminy);
        if (got.lmaxy !== want.lmaxy) report_mismatch("level_max_y", got.lmaxy, want.lmaxy);
        if (got.any !== want.any) report_mismatch("any_present", got.any, want.any);
        if (got.tminx !== want.tminx) report_mismatch("total_min_x", got.tminx, want.tminx);
        if (got.tmaxx !== want.tmaxx) report_mismatch("total_max_x", got.tmaxx, want.tmaxx);
        if (got.tminy !== want.tminy) report_mismatch("total_min_y", got.tminy, want.tminy);
        if (got.tmaxy !== want.tmaxy) report_mismatch("total_max_y", got.tmaxy, want.tmaxy);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Long receiver hold-off while the sender keeps pushing
  initial begin
    wait (stim_done == 0 && directed.size() != 0);
    repeat (3000) @(posedge clk);
    hold_off = 1;
    repeat (2000) @(posedge clk);
    hold_off = 0;
  end

  function automatic logic [7:0] pick_coord(input int mode);
    case ($urandom_range(9))
      0: return 8'h80;
      1: return 8'h7F;
      default: return mode ? 8'($urandom_range(255)) : 8'($urandom_range(6) - 3);
    endcase
  endfunction

  initial begin
    logic [1:0] op;
    logic [7:0] x, y;
    logic [3:0] lv;
    int r;
    // extremes and every operation
    add_row(bbt_pkg::OP_ADD, 8'h80, 8'h7F, 4'h8, 1, {8'h7F, 8'h7F, 8'h80, 8'h80, 1'b1,
                                                     8'h7F, 8'h7F, 8'h80, 8'h80, 1'b1, 1'b1});
    add_row(bbt_pkg::OP_ADD, 8'h7F, 8'h80, 4'h8, 0, '0);
    add_row(bbt_pkg::OP_ADD, 8'h7F, 8'h80, 4'h8, 0, '0);
    add_row(bbt_pkg::OP_ADD, 8'h00, 8'h00, 4'h7, 0, '0);
    add_row(bbt_pkg::OP_REMOVE, 8'h05, 8'h05, 4'h3, 0, '0);   // absent level
    add_row(bbt_pkg::OP_REMOVE, 8'h11, 8'h22, 4'h8, 0, '0);   // no count there
    add_row(bbt_pkg::OP_REMOVE, 8'h7F, 8'h80, 4'h8, 0, '0);
    add_row(bbt_pkg::OP_REMOVE, 8'h7F, 8'h80, 4'h8, 0, '0);
    add_row(bbt_pkg::OP_REMOVE, 8'h80, 8'h7F, 4'h8, 0, '0);   // level vanishes
    add_row(2'd3, 8'hFF, 8'hFF, 4'hF, 0, '0);                  // unused code
    add_row(bbt_pkg::OP_ADD, 8'h55, 8'hAA, 4'hF, 0, '0);
    add_row(bbt_pkg::OP_CLEAR, 8'h00, 8'h00, 4'h7, 1, 67'd1);
    add_row(bbt_pkg::OP_CLEAR, 8'hFF, 8'hFF, 4'h0, 1, 67'd0);
    add_row(bbt_pkg::OP_ADD, 8'hFF, 8'hFF, 4'h0, 0, '0);
    add_row(bbt_pkg::OP_REMOVE, 8'hFF, 8'h00, 4'h0, 0, '0);   // y left behind, level gone

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_request(directed[i].op, directed[i].x, directed[i].y, directed[i].lv,
                   directed[i].has_exp, directed[i].exp_bits);

    // mostly add/remove on few levels near a cluster, rare clears and noise
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_phase = (n >= 400 && n < 500);
      r = $urandom_range(99);
      op = (r < 55) ? bbt_pkg::OP_ADD : (r < 93) ? bbt_pkg::OP_REMOVE :
           (r < 97) ? 2'd3 : bbt_pkg::OP_CLEAR;
      x = pick_coord(n % 4 == 0);
      y = pick_coord(n % 5 == 0);
      lv = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(2));
      send_request(op, x, y, lv, 0, '0);
    end
    in_tvalid <= 1'b0;
    quiet_phase = 0;
    stim_done = 1;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
